>>> rtl/lzdn_pkg.sv
// shared types and constants for the nibble-coded lz77 decoder
package lzdn_pkg;

	localparam int HIST_DEPTH = 256;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int LANES      = 8;
	localparam int LANE_W     = $clog2(LANES + 1);

	// header flag bits
	localparam int HDR_PAIR  = 0;
	localparam int HDR_NEXT  = 1;
	localparam int HDR_PAIR4 = 2;
	localparam int HDR_NEXT4 = 3;

	// final status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_BADOF = 2'd2;
	localparam logic [1:0] ST_LIMIT = 2'd3;

	// parse phases
	localparam logic [3:0] PH_HDR   = 4'd0;
	localparam logic [3:0] PH_OFF4  = 4'd1;
	localparam logic [3:0] PH_LEN4  = 4'd2;
	localparam logic [3:0] PH_OFFH  = 4'd3;
	localparam logic [3:0] PH_OFFL  = 4'd4;
	localparam logic [3:0] PH_LENH  = 4'd5;
	localparam logic [3:0] PH_LENL  = 4'd6;
	localparam logic [3:0] PH_NXT4  = 4'd7;
	localparam logic [3:0] PH_NXTH  = 4'd8;
	localparam logic [3:0] PH_NXTL  = 4'd9;

	// result beat as handed to the output register
	typedef struct packed {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic        burst_last;
		logic        stream_end;
		logic [31:0] total;
		logic [1:0]  status;
	} res_t;

endpackage

>>> rtl/lz77_delta_nibble_decoder.sv
// top level of the nibble-coded lz77 decoder
//
// channel   dir  tdata / tuser                                           done at
// s_axis    in   tdata[7:0] in_byte, tlast stream_last                   tvalid&tready
// m_axis    out  tdata[63:0] out_bytes,[67:64] byte_count,[99:68] total, tvalid&tready
//                [101:100] status; tuser stream_end; tlast burst_last
// cfg       in   cfg_data output_limit                                  cfg_valid&cfg_ready
//
// one input byte is accepted, then parsed a nibble at a time and closed by a flush step;
// a finished token adds a setup step, reads each copied byte from history and then writes
// it, emits its next byte and hands out each full eight-byte beat.
// the last byte of a stream adds the stream end beat.
// results leave through one output register; a full register stalls the copy.
// reset clears all control state; the history memory is left undefined.
module lz77_delta_nibble_decoder (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,   // in_byte
	input  logic          s_axis_tlast,   // stream_last
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [103:0]  m_axis_tdata,   // out_bytes, byte_count, total_bytes, status
	output logic          m_axis_tlast,   // burst_last
	output logic          m_axis_tuser,   // stream_end
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [31:0]   cfg_data        // output_limit
);

	typedef enum logic [2:0] {
		S_IDLE, S_NIB, S_COPY, S_WAIT, S_NEXT, S_FLUSH, S_END
	} state_t;

	state_t      state_q;
	logic [31:0] limit_q;
	logic [3:0]  phase_q, hdr_q, acc_q, lo_q, held_q;
	logic        second_q, last_q, limit_hit_q;
	logic [1:0]  err_q;
	logic [7:0]  poff_q, plen_q, pnext_q, copy_q;
	logic [31:0] prod_q;
	logic [63:0] word_q;
	logic [3:0]  cnt_q;
	logic        copy_rd_q;   // a read is in flight
	logic        obuf_v_q;
	lzdn_pkg::res_t obuf_q;

	// history memory
	logic                        h_we;
	logic [lzdn_pkg::HIST_AW-1:0] h_waddr, h_raddr;
	logic [7:0]                  h_wdata, h_rdata;
	logic [7:0]                  fwd_q;
	logic                        fwd_v_q;

	lzdn_history u_hist (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = (state_q == S_IDLE) && !obuf_v_q;
	assign m_axis_tvalid = obuf_v_q;
	assign m_axis_tdata  = {2'b00, obuf_q.status, obuf_q.total, obuf_q.count, obuf_q.bytes};
	assign m_axis_tlast  = obuf_q.burst_last;
	assign m_axis_tuser  = obuf_q.stream_end;

	logic obuf_free;
	assign obuf_free = !obuf_v_q || m_axis_tready;

	// current nibble
	logic [3:0] nib;
	assign nib = lo_q;

	// token parse helpers
	logic [7:0] nx_sel;
	logic [7:0] len_eff;
	assign nx_sel  = hdr_q[lzdn_pkg::HDR_NEXT] ? pnext_q : 8'd0;
	assign len_eff = hdr_q[lzdn_pkg::HDR_PAIR] ? plen_q : 8'd0;

	// copy source byte: forward when reading the byte written last cycle
	logic [7:0] src_byte;
	assign src_byte = fwd_v_q ? fwd_q : h_rdata;

	// read address of next copy byte
	assign h_raddr = lzdn_pkg::HIST_AW'(prod_q - 32'(poff_q));

	// byte emission by a state this cycle
	logic       emit;
	logic [7:0] emit_byte;
	always_comb begin
		emit = 1'b0;
		emit_byte = 8'd0;
		if (state_q == S_COPY && copy_rd_q && cnt_q != 4'(lzdn_pkg::LANES)) begin
			emit = 1'b1;
			emit_byte = src_byte;
		end else if (state_q == S_NEXT && cnt_q != 4'(lzdn_pkg::LANES)
			&& prod_q < limit_q) begin
			emit = 1'b1;
			emit_byte = pnext_q;
		end
	end
	assign h_we    = emit;
	assign h_waddr = lzdn_pkg::HIST_AW'(prod_q);
	assign h_wdata = emit_byte;

	logic stopped;
	assign stopped = (err_q != 2'd0) || limit_hit_q;

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= 32'hFFFF_FFFF;
			phase_q <= lzdn_pkg::PH_HDR;
			hdr_q <= '0; acc_q <= '0; lo_q <= '0; held_q <= '0;
			second_q <= 1'b0; last_q <= 1'b0; limit_hit_q <= 1'b0; err_q <= '0;
			poff_q <= '0; plen_q <= '0; pnext_q <= '0; copy_q <= '0;
			prod_q <= '0; word_q <= '0; cnt_q <= '0;
			copy_rd_q <= 1'b0; obuf_v_q <= 1'b0; obuf_q <= '0;
			fwd_q <= '0; fwd_v_q <= 1'b0;
		end else begin
			if (m_axis_tready) obuf_v_q <= 1'b0;
			fwd_v_q <= 1'b0;
			if (emit) begin
				word_q[8*cnt_q[2:0] +: 8] <= emit_byte;
				cnt_q <= cnt_q + 4'd1;
				prod_q <= prod_q + 32'd1;
				// a copy reading this address next cycle needs the new byte
				fwd_v_q <= (poff_q == 8'd1);
				fwd_q <= emit_byte;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) limit_q <= cfg_data;
					if (s_axis_tvalid) begin
						last_q <= s_axis_tlast;
						word_q <= '0; cnt_q <= '0;
						if (stopped) begin
							state_q <= S_FLUSH;
						end else begin
							lo_q <= s_axis_tdata[7:4];
							acc_q <= acc_q;
							second_q <= 1'b0;
							state_q <= S_NIB;
							// low nibble waits for the second parse cycle
							held_q <= s_axis_tdata[3:0];
						end
					end
				end
				S_NIB: begin
					// decode one nibble; default next nibble step
					logic run;
					logic after;
					logic [3:0] nph;
					run = 1'b0; after = 1'b0; nph = phase_q;
					case (phase_q)
						lzdn_pkg::PH_HDR: begin
							hdr_q <= nib;
							if (nib[lzdn_pkg::HDR_PAIR])
								nph = nib[lzdn_pkg::HDR_PAIR4] ? lzdn_pkg::PH_OFF4
									: lzdn_pkg::PH_OFFH;
							else if (nib[lzdn_pkg::HDR_NEXT])
								nph = nib[lzdn_pkg::HDR_NEXT4] ? lzdn_pkg::PH_NXT4
									: lzdn_pkg::PH_NXTH;
							else begin
								run = 1'b1; pnext_q <= 8'd0; nph = lzdn_pkg::PH_HDR;
							end
						end
						lzdn_pkg::PH_OFF4: begin
							poff_q <= poff_q + {4'd0, nib}; nph = lzdn_pkg::PH_LEN4;
						end
						lzdn_pkg::PH_LEN4: begin
							plen_q <= plen_q + {4'd0, nib}; after = 1'b1;
						end
						lzdn_pkg::PH_OFFH: begin acc_q <= nib; nph = lzdn_pkg::PH_OFFL; end
						lzdn_pkg::PH_OFFL: begin
							poff_q <= poff_q + {acc_q, nib}; nph = lzdn_pkg::PH_LENH;
						end
						lzdn_pkg::PH_LENH: begin acc_q <= nib; nph = lzdn_pkg::PH_LENL; end
						lzdn_pkg::PH_LENL: begin
							plen_q <= plen_q + {acc_q, nib}; after = 1'b1;
						end
						lzdn_pkg::PH_NXT4: begin
							pnext_q <= pnext_q + {4'd0, nib}; run = 1'b1;
							nph = lzdn_pkg::PH_HDR;
						end
						lzdn_pkg::PH_NXTH: begin acc_q <= nib; nph = lzdn_pkg::PH_NXTL; end
						lzdn_pkg::PH_NXTL: begin
							pnext_q <= pnext_q + {acc_q, nib}; run = 1'b1;
							nph = lzdn_pkg::PH_HDR;
						end
						default: nph = lzdn_pkg::PH_HDR;
					endcase
					if (after) begin
						if (hdr_q[lzdn_pkg::HDR_NEXT])
							nph = hdr_q[lzdn_pkg::HDR_NEXT4] ? lzdn_pkg::PH_NXT4
								: lzdn_pkg::PH_NXTH;
						else begin
							run = 1'b1; pnext_q <= 8'd0; nph = lzdn_pkg::PH_HDR;
						end
					end
					phase_q <= nph;
					if (run) begin
						// token runs once the parse registers settle
						state_q <= S_WAIT;
					end else if (!second_q && !(last_q && nph == lzdn_pkg::PH_HDR)) begin
						second_q <= 1'b1;
						lo_q <= held_q;
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_WAIT: begin
					// start the token: check offset, clip length to the limit
					logic [31:0] room;
					logic [31:0] l32;
					room = limit_q - prod_q;
					l32 = {24'd0, len_eff};
					if (l32 > room) l32 = room;
					if (len_eff != 8'd0 && (poff_q == 8'd0 || {24'd0, poff_q} > prod_q)) begin
						err_q <= lzdn_pkg::ST_BADOF;
						state_q <= S_FLUSH;
					end else if (l32 != 32'd0) begin
						copy_q <= l32[7:0];
						copy_rd_q <= 1'b0;
						state_q <= S_COPY;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_COPY: begin
					if (cnt_q == 4'(lzdn_pkg::LANES)) begin
						if (obuf_free) begin
							obuf_v_q <= 1'b1;
							obuf_q <= '{bytes: word_q, count: cnt_q, burst_last: 1'b0,
								stream_end: 1'b0, total: prod_q, status: lzdn_pkg::ST_OK};
							cnt_q <= '0; word_q <= '0;
						end
						copy_rd_q <= 1'b0;
					end else if (!copy_rd_q) begin
						copy_rd_q <= 1'b1;
					end else begin
						// byte emitted this cycle; a fresh read follows
						copy_rd_q <= 1'b0;
						copy_q <= copy_q - 8'd1;
						if (copy_q == 8'd1) state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (prod_q >= limit_q) begin
						limit_hit_q <= 1'b1;
						state_q <= S_FLUSH;
					end else if (cnt_q == 4'(lzdn_pkg::LANES)) begin
						if (obuf_free) begin
							obuf_v_q <= 1'b1;
							obuf_q <= '{bytes: word_q, count: cnt_q, burst_last: 1'b0,
								stream_end: 1'b0, total: prod_q, status: lzdn_pkg::ST_OK};
							cnt_q <= '0; word_q <= '0;
						end
					end else begin
						// next byte emitted; continue with low nibble if any
						if (!second_q && !(last_q && phase_q == lzdn_pkg::PH_HDR)) begin
							second_q <= 1'b1;
							lo_q <= held_q;
							state_q <= S_NIB;
						end else begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (cnt_q == 4'd0) begin
						state_q <= last_q ? S_END : S_IDLE;
					end else if (obuf_free) begin
						obuf_v_q <= 1'b1;
						obuf_q <= '{bytes: word_q, count: cnt_q, burst_last: !last_q,
							stream_end: 1'b0, total: prod_q, status: lzdn_pkg::ST_OK};
						cnt_q <= '0; word_q <= '0;
						state_q <= last_q ? S_END : S_IDLE;
					end
				end
				S_END: begin
					if (obuf_free) begin
						logic [1:0] st;
						if (err_q != 2'd0) st = err_q;
						else if (limit_hit_q) st = lzdn_pkg::ST_LIMIT;
						else if (phase_q != lzdn_pkg::PH_HDR) st = lzdn_pkg::ST_TRUNC;
						else st = lzdn_pkg::ST_OK;
						obuf_v_q <= 1'b1;
						obuf_q <= '{bytes: 64'd0, count: 4'd0, burst_last: 1'b1,
							stream_end: 1'b1, total: prod_q, status: st};
						phase_q <= lzdn_pkg::PH_HDR; hdr_q <= '0; acc_q <= '0;
						poff_q <= '0; plen_q <= '0; pnext_q <= '0; prod_q <= '0;
						limit_hit_q <= 1'b0; err_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the output register never holds more than eight bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (obuf_q.count <= 4'(lzdn_pkg::LANES)))
		else $error("result byte count too large");

	// a stream end item carries no bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (obuf_q.count == 4'd0 && m_axis_tlast))
		else $error("stream end item carries data");

	// input is only taken while no token is running
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
		else $error("input accepted without leaving idle");

endmodule

>>> rtl/lzdn_history.sv
// 256-byte history memory, one write and one registered read port
module lzdn_history (
	input  logic                        clk,
	input  logic                        we,
	input  logic [lzdn_pkg::HIST_AW-1:0] waddr,
	input  logic [7:0]                  wdata,
	input  logic [lzdn_pkg::HIST_AW-1:0] raddr,
	output logic [7:0]                  rdata
);

	logic [7:0] mem [lzdn_pkg::HIST_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> tb/sv/tb_lz77_delta_nibble_decoder.sv
// self-checking testbench for the nibble-coded lz77 decoder
module tb_lz77_delta_nibble_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 8000000;
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_beat_t;

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [7:0]    s_axis_tdata;
	logic          s_axis_tlast;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [103:0]  m_axis_tdata;
	logic          m_axis_tlast;
	logic          m_axis_tuser;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [31:0]   cfg_data;

	lz77_delta_nibble_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// compressed beats waiting for the driver, decoded beats waiting for the dut
	in_beat_t       pending_bytes[$];
	lzdn_pkg::res_t decoded_beats[$];

	int errors = 0;
	int cycles = 0;
	int bytes_taken = 0;
	int beats_checked = 0;
	int streams_closed = 0;
	int limit_changes = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int recv_hold = 0;
	bit hold_done = 0;
	bit running = 0;
	bit pending_take = 0;

	// decoder state mirror
	logic [31:0] lim;
	logic [7:0]  hist [0:lzdn_pkg::HIST_DEPTH-1];
	logic [3:0]  phase;
	logic [3:0]  hdr;
	logic [3:0]  acc;
	logic [7:0]  poff, plen, pnxt;
	logic [31:0] produced;
	logic        lim_hit;
	logic [1:0]  err_code;
	logic [7:0]  step_bytes[$];

	function automatic void clear_stream();
		phase = lzdn_pkg::PH_HDR; hdr = 4'd0; acc = 4'd0;
		poff = 8'd0; plen = 8'd0; pnxt = 8'd0;
		produced = 32'd0; lim_hit = 1'b0; err_code = lzdn_pkg::ST_OK;
	endfunction

	function automatic bit halted();
		return err_code != lzdn_pkg::ST_OK || lim_hit;
	endfunction

	function automatic void put_out(logic [7:0] b);
		hist[produced[lzdn_pkg::HIST_AW-1:0]] = b;
		produced = produced + 32'd1;
		step_bytes.push_back(b);
	endfunction

	// copy then literal for one finished token
	function automatic void run_copy();
		logic [31:0] len, off, room;
		logic [7:0]  nx;
		logic [31:0] src;
		len = hdr[lzdn_pkg::HDR_PAIR] ? {24'd0, plen} : 32'd0;
		off = {24'd0, poff};
		nx = hdr[lzdn_pkg::HDR_NEXT] ? pnxt : 8'd0;
		pnxt = nx;
		phase = lzdn_pkg::PH_HDR;
		if (len > 0) begin
			if (off == 0 || off > produced) begin
				err_code = lzdn_pkg::ST_BADOF;
				return;
			end
			room = lim - produced;
			if (len > room) len = room;
			for (int i = 0; i < len; i++) begin
				src = produced - off;
				put_out(hist[src[lzdn_pkg::HIST_AW-1:0]]);
			end
		end
		if (produced >= lim) begin
			lim_hit = 1'b1;
			return;
		end
		put_out(nx);
	endfunction

	function automatic void pair_done();
		if (hdr[lzdn_pkg::HDR_NEXT])
			phase = hdr[lzdn_pkg::HDR_NEXT4] ? lzdn_pkg::PH_NXT4 : lzdn_pkg::PH_NXTH;
		else run_copy();
	endfunction

	function automatic void parse_nibble(logic [3:0] n);
		case (phase)
			lzdn_pkg::PH_HDR: begin
				hdr = n;
				if (n[lzdn_pkg::HDR_PAIR])
					phase = n[lzdn_pkg::HDR_PAIR4] ? lzdn_pkg::PH_OFF4 : lzdn_pkg::PH_OFFH;
				else pair_done();
			end
			lzdn_pkg::PH_OFF4: begin poff = poff + {4'd0, n}; phase = lzdn_pkg::PH_LEN4; end
			lzdn_pkg::PH_LEN4: begin plen = plen + {4'd0, n}; pair_done(); end
			lzdn_pkg::PH_OFFH: begin acc = n; phase = lzdn_pkg::PH_OFFL; end
			lzdn_pkg::PH_OFFL: begin poff = poff + {acc, n}; phase = lzdn_pkg::PH_LENH; end
			lzdn_pkg::PH_LENH: begin acc = n; phase = lzdn_pkg::PH_LENL; end
			lzdn_pkg::PH_LENL: begin plen = plen + {acc, n}; pair_done(); end
			lzdn_pkg::PH_NXT4: begin pnxt = pnxt + {4'd0, n}; run_copy(); end
			lzdn_pkg::PH_NXTH: begin acc = n; phase = lzdn_pkg::PH_NXTL; end
			lzdn_pkg::PH_NXTL: begin pnxt = pnxt + {acc, n}; run_copy(); end
			default: phase = lzdn_pkg::PH_HDR;
		endcase
	endfunction

	// decode one compressed byte and queue the beats it should cause
	function automatic void decode_byte(logic [7:0] b, logic last);
		logic [31:0] start;
		int pos, cnt;
		lzdn_pkg::res_t r;
		step_bytes.delete();
		start = produced;
		if (!halted()) begin
			parse_nibble(b[7:4]);
			if (!halted() && !(last && phase == lzdn_pkg::PH_HDR)) parse_nibble(b[3:0]);
		end
		pos = 0;
		while (pos < step_bytes.size()) begin
			cnt = step_bytes.size() - pos;
			if (cnt > lzdn_pkg::LANES) cnt = lzdn_pkg::LANES;
			r = '0;
			for (int i = 0; i < cnt; i++) r.bytes[8*i +: 8] = step_bytes[pos + i];
			pos += cnt;
			r.count = 4'(cnt);
			r.burst_last = !last && pos >= step_bytes.size();
			r.total = start + 32'(pos);
			decoded_beats.push_back(r);
		end
		if (last) begin
			r = '0;
			r.burst_last = 1'b1;
			r.stream_end = 1'b1;
			r.total = produced;
			if (err_code != lzdn_pkg::ST_OK) r.status = err_code;
			else if (lim_hit) r.status = lzdn_pkg::ST_LIMIT;
			else if (phase != lzdn_pkg::PH_HDR) r.status = lzdn_pkg::ST_TRUNC;
			else r.status = lzdn_pkg::ST_OK;
			decoded_beats.push_back(r);
			clear_stream();
		end
	endfunction

	// clock
	initial clk = 0;
	always #4 clk = ~clk;

	// acceptance, prediction and checking at the rising edge
	always @(posedge clk) begin
		lzdn_pkg::res_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			if (arst_n && cfg_valid && cfg_ready) lim = cfg_data;
			if (arst_n && s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
				bytes_taken++;
				pending_take = 1;
			end
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (decoded_beats.size() == 0) begin
					$error("unexpected beat: tdata=%h tuser=%b tlast=%b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					want = decoded_beats.pop_front();
					beats_checked++;
					if (want.stream_end) streams_closed++;
					if (m_axis_tdata[63:0] !== want.bytes) begin
						$error("out_bytes: expected %h, got %h", want.bytes, m_axis_tdata[63:0]);
						errors++;
					end
					if (m_axis_tdata[67:64] !== want.count) begin
						$error("byte_count: expected %0d, got %0d", want.count,
							m_axis_tdata[67:64]);
						errors++;
					end
					if (m_axis_tdata[99:68] !== want.total) begin
						$error("total_bytes: expected %0d, got %0d", want.total,
							m_axis_tdata[99:68]);
						errors++;
					end
					if (m_axis_tdata[101:100] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status,
							m_axis_tdata[101:100]);
						errors++;
					end
					if (m_axis_tlast !== want.burst_last) begin
						$error("burst_last: expected %b, got %b", want.burst_last, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser !== want.stream_end) begin
						$error("stream_end: expected %b, got %b", want.stream_end, m_axis_tuser);
						errors++;
					end
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// input driver: holds a beat until taken, then idles or loads the next one
	always @(negedge clk) begin
		in_beat_t nb;
		if (running) begin
			if (s_axis_tvalid && !pending_take) begin
				// still waiting for the beat to be taken
			end else if (send_gap > 0) begin
				s_axis_tvalid = 0;
				send_gap--;
			end else if (pending_bytes.size() > 0) begin
				nb = pending_bytes.pop_front();
				s_axis_tdata = nb.data;
				s_axis_tlast = nb.last;
				s_axis_tvalid = 1;
				send_gap = pick_gap();
			end else begin
				s_axis_tvalid = 0;
			end
			pending_take = 0;
		end
	end

	// output backpressure, with one long hold-off while the sender keeps going
	always @(negedge clk) begin
		if (running) begin
			if (!hold_done && bytes_taken >= 40) begin
				hold_done = 1;
				recv_hold = 400;
			end
			if (recv_hold > 0) begin
				m_axis_tready = 0;
				recv_hold--;
			end else if (recv_gap > 0) begin
				m_axis_tready = 0;
				recv_gap--;
			end else begin
				m_axis_tready = 1;
				recv_gap = pick_gap();
			end
		end
	end

	task automatic add_byte(logic [7:0] b, logic last);
		in_beat_t nb;
		nb.data = b;
		nb.last = last;
		pending_bytes.push_back(nb);
	endtask

	// build one stream of mostly well-formed tokens
	task automatic build_stream(inout int added);
		logic [3:0]  nibs[$];
		logic [3:0]  h;
		logic [7:0]  g_off, g_len, len_was, want_off, d;
		int          g_prod, ntok, top, r, cut;
		g_off = 0; g_len = 0; g_prod = 0;
		if ($urandom_range(0, 9) == 0) begin
			// noise stream
			ntok = $urandom_range(1, 8);
			for (int i = 0; i < ntok; i++) add_byte(8'($urandom_range(0, 255)), i == ntok - 1);
			added += ntok;
			return;
		end
		ntok = $urandom_range(1, 8);
		for (int t = 0; t < ntok; t++) begin
			h = 4'($urandom_range(0, 15));
			nibs.push_back(h);
			if (h[lzdn_pkg::HDR_PAIR]) begin
				if (h[lzdn_pkg::HDR_PAIR4]) begin
					d = 8'($urandom_range(0, 15)); nibs.push_back(d[3:0]); g_off += d;
					d = 8'($urandom_range(0, 15)); nibs.push_back(d[3:0]); g_len += d;
				end else begin
					len_was = g_len;
					top = g_prod > 255 ? 255 : g_prod;
					if (top == 0 || $urandom_range(0, 19) == 0) begin
						want_off = 8'($urandom_range(0, 255));
						g_len = (top == 0) ? 8'd0 : 8'($urandom_range(0, 255));
					end else begin
						want_off = 8'($urandom_range(1, top));
						r = $urandom_range(0, 99);
						if (r < 85) g_len = 8'($urandom_range(0, 10));
						else if (r < 97) g_len = 8'($urandom_range(11, 60));
						else g_len = 8'($urandom_range(61, 255));
					end
					d = want_off - g_off;
					g_off = want_off;
					nibs.push_back(d[7:4]); nibs.push_back(d[3:0]);
					// length field is a delta against the previous length
					d = g_len - len_was;
					nibs.push_back(d[7:4]); nibs.push_back(d[3:0]);
				end
			end
			if (h[lzdn_pkg::HDR_NEXT]) begin
				nibs.push_back(4'($urandom_range(0, 15)));
				if (!h[lzdn_pkg::HDR_NEXT4]) nibs.push_back(4'($urandom_range(0, 15)));
			end
			g_prod += (h[lzdn_pkg::HDR_PAIR] ? int'(g_len) : 0) + 1;
		end
		// sometimes cut one to three nibbles off the end of the stream
		if ($urandom_range(0, 9) == 0 && nibs.size() > 1) begin
			cut = $urandom_range(1, nibs.size() - 1 < 3 ? nibs.size() - 1 : 3);
			for (int i = 0; i < cut; i++) void'(nibs.pop_back());
		end
		if (nibs.size() % 2 != 0) nibs.push_back(4'($urandom_range(0, 15)));
		for (int i = 0; i < nibs.size(); i += 2)
			add_byte({nibs[i], nibs[i+1]}, i + 2 >= nibs.size());
		added += nibs.size() / 2;
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || s_axis_tvalid || decoded_beats.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		@(negedge clk);
		cfg_data = v;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
		limit_changes++;
	endtask

	initial begin
		logic [31:0] limits[7];
		int added;
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
		m_axis_tready = 0;
		cfg_valid = 0; cfg_data = 0;
		lim = 32'hFFFF_FFFF;
		for (int i = 0; i < lzdn_pkg::HIST_DEPTH; i++) hist[i] = 0;
		clear_stream();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		running = 1;

		// directed: next byte 0xff, final low nibble ignored
		add_byte(8'h2F, 0); add_byte(8'hF0, 1);
		// nibble next, absent next, short pair copy, then a truncated token
		add_byte(8'hA7, 0); add_byte(8'h05, 0); add_byte(8'h13, 0); add_byte(8'hDF, 1);
		// bad offset on the very first copy
		add_byte(8'h51, 0); add_byte(8'h10, 1);
		// all-zero and all-one bytes
		add_byte(8'h00, 0); add_byte(8'hFF, 0); add_byte(8'hFF, 0); add_byte(8'h00, 1);
		// longest copy: 255 bytes from one back
		add_byte(8'h01, 0); add_byte(8'h01, 0); add_byte(8'hFF, 1);
		// byte-wide next and pair fields; the copy offset reaches before the stream start
		add_byte(8'h30, 0); add_byte(8'h40, 0); add_byte(8'h13, 0); add_byte(8'h04, 0);
		add_byte(8'h00, 1);
		wait_idle();

		limits = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd9, 32'd64, 32'd300, 32'hFFFF_FFFE};
		foreach (limits[p]) begin
			write_limit(limits[p]);
			added = 0;
			while (added < (limits[p] == 0 ? 20 : 55)) build_stream(added);
			// the sender pauses here until every decoded beat has come back
			wait_idle();
		end

		$display("fed %0d compressed bytes in %0d streams over %0d limit settings",
			bytes_taken, streams_closed, limit_changes);
		$display("checked %0d decoded beats in %0d cycles", beats_checked, cycles);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
